FILE: sv/tx_block_sequence_assembler_macros.svh
// ----------------------------------------------------------------------------
// Transmit block sequence assembler assertion macros
// Shared concurrent check forms, clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef TX_BLOCK_SEQUENCE_ASSEMBLER_MACROS_SVH
`define TX_BLOCK_SEQUENCE_ASSEMBLER_MACROS_SVH

// Same-cycle implication
`define TBSA_ASSERT_IMP(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error("tbsa same-cycle check failed");

// Next-cycle implication
`define TBSA_ASSERT_NXT(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error("tbsa next-cycle check failed");

`endif

FILE: sv/tbsa_pkg.sv
// ----------------------------------------------------------------------------
// Transmit block sequence assembler package
// Shared constants, codes and item types for the assembler modules.
// ----------------------------------------------------------------------------
package tbsa_pkg;

  // Buffer limits
  localparam int unsigned MAX_BUFFER_BYTES = 1048576;
  localparam int unsigned BYTES_W          = 21;
  localparam logic [BYTES_W-1:0] SIZE_LIMIT  = BYTES_W'(MAX_BUFFER_BYTES);
  localparam logic [BYTES_W-1:0] STAMP_BYTES = BYTES_W'(8);

  // Stream widths
  localparam int unsigned IN_TDATA_W  = 144;
  localparam int unsigned OUT_TDATA_W = 128;
  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned CFG_DATA_W  = 32;

  // Item kinds
  localparam logic FUNC_HEADER = 1'b0;
  localparam logic FUNC_PUSH   = 1'b1;

  typedef enum logic [2:0] {
    VERDICT_ACCEPT    = 3'd0,
    VERDICT_BAD_MAGIC = 3'd1,
    VERDICT_AWAIT     = 3'd2,
    VERDICT_ORDER     = 3'd3,
    VERDICT_FULL      = 3'd4,
    VERDICT_EMPTY     = 3'd5,
    VERDICT_PUSHED    = 3'd6,
    VERDICT_NOT_READY = 3'd7
  } verdict_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_MAGIC_WORD  = 2'd0,
    CFG_BUFFER_SIZE = 2'd1,
    CFG_STAMP_EN    = 2'd2,
    CFG_STAMP_STEP  = 2'd3
  } cfg_index_t;

  typedef struct packed {
    logic [31:0]        magic_word;
    logic [BYTES_W-1:0] buffer_bytes;
    logic               timestamp_enable;
    logic [31:0]        timestamp_step;
  } cfg_t;

  typedef struct packed {
    logic        func;
    logic [31:0] hdr_magic;
    logic [63:0] hdr_seqno;
    logic [15:0] hdr_block_index;
    logic [15:0] hdr_block_count;
    logic [15:0] payload_bytes;
  } item_t;

  typedef struct packed {
    verdict_t           verdict;
    logic [BYTES_W-1:0] write_offset;
    logic [15:0]        accepted_bytes;
    logic               stamp_write;
    logic [63:0]        stamp_value;
    logic               buffer_ready;
    logic               time_wrap;
    logic               time_gap;
    logic [BYTES_W-1:0] fill_level;
  } result_t;

endpackage

FILE: sv/tbsa_cfg_regs.sv
// ----------------------------------------------------------------------------
// Transmit block sequence assembler configuration registers
// Write-only register file for magic, buffer size and timestamp settings.
// ----------------------------------------------------------------------------
module tbsa_cfg_regs (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [tbsa_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [tbsa_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  output tbsa_pkg::cfg_t                    cfg_o
);
  import tbsa_pkg::*;

  cfg_t cfg_r;

  // Decode and store writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.magic_word       <= '0;
      cfg_r.buffer_bytes     <= BYTES_W'(65536);
      cfg_r.timestamp_enable <= 1'b0;
      cfg_r.timestamp_step   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_MAGIC_WORD:  cfg_r.magic_word       <= cfg_wdata;
        CFG_BUFFER_SIZE: cfg_r.buffer_bytes     <= cfg_wdata[BYTES_W-1:0];
        CFG_STAMP_EN:    cfg_r.timestamp_enable <= cfg_wdata[0];
        CFG_STAMP_STEP:  cfg_r.timestamp_step   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_r;

endmodule

FILE: sv/tbsa_eval.sv
// ----------------------------------------------------------------------------
// Transmit block sequence assembler evaluation stage
// Holds the fill state; judges one registered item per cycle, commits on upd_i.
// ----------------------------------------------------------------------------
module tbsa_eval (
  input  logic                          clk,
  input  logic                          rst_n,
  input  tbsa_pkg::cfg_t                cfg_i,
  input  tbsa_pkg::item_t               item_i,
  input  logic                          upd_i,
  output tbsa_pkg::result_t             res_o,
  output logic [tbsa_pkg::BYTES_W-1:0]  bytes_used_o
);
  import tbsa_pkg::*;

  logic [BYTES_W-1:0] bytes_used_r, bytes_used_nxt;
  logic [15:0]        last_block_r, last_block_nxt;
  logic [15:0]        exp_blocks_r, exp_blocks_nxt;
  logic [63:0]        exp_stamp_r,  exp_stamp_nxt;

  logic [BYTES_W-1:0] size;
  logic               full;
  logic               first;
  logic               stamp;
  logic [BYTES_W-1:0] room;
  logic [BYTES_W-1:0] free_b;
  logic [BYTES_W-1:0] offset;
  logic [15:0]        take;
  logic               seq_bad;
  logic [BYTES_W-1:0] used_after;
  verdict_t           verdict;

  // Effective buffer size and fill checks
  always_comb begin
    size   = (cfg_i.buffer_bytes > SIZE_LIMIT) ? SIZE_LIMIT : cfg_i.buffer_bytes;
    full   = (bytes_used_r >= size);
    first  = (bytes_used_r == '0);
    stamp  = first && cfg_i.timestamp_enable;
    room   = size - bytes_used_r;
    if (stamp) begin
      free_b = (room >= STAMP_BYTES) ? room - STAMP_BYTES : '0;
      offset = bytes_used_r + STAMP_BYTES;
    end else begin
      free_b = room;
      offset = bytes_used_r;
    end
    take = ({5'd0, item_i.payload_bytes} < free_b) ? item_i.payload_bytes
                                                   : free_b[15:0];
    seq_bad = (({1'b0, last_block_r} + 17'd1) != {1'b0, item_i.hdr_block_index}) ||
              (exp_blocks_r != item_i.hdr_block_count) ||
              (exp_stamp_r != item_i.hdr_seqno);
  end

  // Judge the item and work out the next state
  always_comb begin
    bytes_used_nxt = bytes_used_r;
    last_block_nxt = last_block_r;
    exp_blocks_nxt = exp_blocks_r;
    exp_stamp_nxt  = exp_stamp_r;
    verdict        = VERDICT_NOT_READY;
    res_o          = '0;

    if (item_i.func == FUNC_PUSH) begin
      if (full) begin
        bytes_used_nxt = '0;
        exp_stamp_nxt  = exp_stamp_r + {32'd0, cfg_i.timestamp_step};
        verdict        = VERDICT_PUSHED;
      end else begin
        verdict = VERDICT_NOT_READY;
      end
    end else if (full) begin
      verdict = VERDICT_FULL;
    end else if (item_i.hdr_magic != cfg_i.magic_word) begin
      verdict = VERDICT_BAD_MAGIC;
    end else if (take == '0) begin
      verdict = VERDICT_EMPTY;
    end else if (first) begin
      if (item_i.hdr_block_index != '0) begin
        verdict = VERDICT_AWAIT;
      end else begin
        res_o.time_wrap = (item_i.hdr_seqno < exp_stamp_r);
        res_o.time_gap  = (item_i.hdr_seqno > exp_stamp_r);
        last_block_nxt  = '0;
        exp_blocks_nxt  = item_i.hdr_block_count;
        exp_stamp_nxt   = item_i.hdr_seqno;
        verdict         = VERDICT_ACCEPT;
      end
    end else if (seq_bad) begin
      bytes_used_nxt = '0;
      verdict        = VERDICT_ORDER;
    end else begin
      last_block_nxt = item_i.hdr_block_index;
      verdict        = VERDICT_ACCEPT;
    end

    // Place accepted payload and the head timestamp
    if (verdict == VERDICT_ACCEPT) begin
      res_o.write_offset   = offset;
      res_o.accepted_bytes = take;
      bytes_used_nxt       = offset + {5'd0, take};
      if (stamp) begin
        res_o.stamp_write = 1'b1;
        res_o.stamp_value = item_i.hdr_seqno;
      end
    end

    used_after         = bytes_used_nxt;
    res_o.verdict      = verdict;
    res_o.buffer_ready = (used_after >= size);
    res_o.fill_level   = used_after;
  end

  // Commit state when the item moves on
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bytes_used_r <= '0;
      last_block_r <= '0;
      exp_blocks_r <= '0;
      exp_stamp_r  <= '0;
    end else if (upd_i) begin
      bytes_used_r <= bytes_used_nxt;
      last_block_r <= last_block_nxt;
      exp_blocks_r <= exp_blocks_nxt;
      exp_stamp_r  <= exp_stamp_nxt;
    end
  end

  assign bytes_used_o = bytes_used_r;

endmodule

FILE: sv/tx_block_sequence_assembler.sv
// ----------------------------------------------------------------------------
// Transmit block sequence assembler
// An accepted item passes the input register, then the result register,
// before its result is valid. Throughput: one item per cycle unless the sink
// stalls; fill state is read and updated within the single evaluation stage.
// Reset: synchronous active-low rst_n clears fill state, pipeline valids and
// loads register defaults (buffer size 65536).
// ----------------------------------------------------------------------------
`include "tx_block_sequence_assembler_macros.svh"

module tx_block_sequence_assembler (
  input  logic                               clk,
  input  logic                               rst_n,
  // in_tdata: hdr_magic[31:0], hdr_seqno[95:32], hdr_block_index[111:96],
  //           hdr_block_count[127:112], payload_bytes[143:128]
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [tbsa_pkg::IN_TDATA_W-1:0]    in_tdata,
  // in_tuser: func[0]
  input  logic                               in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // out_tdata: write_offset[20:0], accepted_bytes[36:21], stamp_write[37],
  //            stamp_value[101:38], buffer_ready[102], time_wrap[103],
  //            time_gap[104], fill_level[125:105], zero pad[127:126]
  output logic [tbsa_pkg::OUT_TDATA_W-1:0]   out_tdata,
  // out_tuser: verdict[2:0]
  output logic [2:0]                         out_tuser,
  input  logic                               cfg_we,
  input  logic [tbsa_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [tbsa_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import tbsa_pkg::*;

  cfg_t               cfg;
  item_t              item_r;
  logic               item_valid_r;
  result_t            res;
  result_t            res_r;
  logic               out_valid_r;
  logic               out_ld;
  logic               upd;
  logic [BYTES_W-1:0] bytes_used;

  tbsa_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg_o     (cfg)
  );

  // Stage handshake: result register frees when empty or taken
  assign out_ld    = !out_valid_r || out_tready;
  assign in_tready = !item_valid_r || out_ld;
  assign upd       = item_valid_r && out_ld;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else if (in_tready) begin
      item_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r.func            <= in_tuser;
      item_r.hdr_magic       <= in_tdata[31:0];
      item_r.hdr_seqno       <= in_tdata[95:32];
      item_r.hdr_block_index <= in_tdata[111:96];
      item_r.hdr_block_count <= in_tdata[127:112];
      item_r.payload_bytes   <= in_tdata[143:128];
    end
  end

  tbsa_eval u_eval (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_i        (cfg),
    .item_i       (item_r),
    .upd_i        (upd),
    .res_o        (res),
    .bytes_used_o (bytes_used)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_ld) begin
      out_valid_r <= item_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (upd) begin
      res_r <= res;
    end
  end

  // Pack the result item
  assign out_tvalid = out_valid_r;
  assign out_tuser  = res_r.verdict;
  assign out_tdata  = {2'b00, res_r.fill_level, res_r.time_gap, res_r.time_wrap,
                       res_r.buffer_ready, res_r.stamp_value, res_r.stamp_write,
                       res_r.accepted_bytes, res_r.write_offset};

  // Checks
  `TBSA_ASSERT_IMP(a_fill_bound, 1'b1, bytes_used <= SIZE_LIMIT)
  `TBSA_ASSERT_IMP(a_pushed_empty, out_tvalid && (out_tuser == VERDICT_PUSHED), res_r.fill_level == '0)
  `TBSA_ASSERT_IMP(a_stamp_head, out_tvalid && res_r.stamp_write, (res_r.write_offset == STAMP_BYTES) && (out_tuser == VERDICT_ACCEPT))
  `TBSA_ASSERT_NXT(a_push_clears, upd && (res.verdict == VERDICT_PUSHED), bytes_used == '0)

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Transmit block sequence assembler testbench
// Streams header and push items into the assembler under random source gaps
// and sink stalls, predicts each result from a local copy of the fill state
// and registers, and compares every result field against the prediction.
// ----------------------------------------------------------------------------
module tb_top;
  import tbsa_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int PRINT_CAP   = 50;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   in_tuser = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [2:0]             out_tuser;
  logic                   cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

  // Register copies
  logic [31:0]        reg_magic;
  logic [BYTES_W-1:0] reg_size;
  logic               reg_stamp_en;
  logic [31:0]        reg_step;

  // Fill state copies
  logic [BYTES_W-1:0] fill_used;
  logic [15:0]        last_blk;
  logic [15:0]        blk_total;
  logic [63:0]        run_stamp;

  item_t   pending_items[$];
  result_t expected_results[$];
  item_t   item_on_bus;
  result_t want;
  int      items_queued = 0;
  int      items_taken = 0;
  int      results_seen = 0;
  int      mismatches = 0;
  int      settings_used = 0;
  int      verdict_count[8];
  int      send_wait = 0;
  int      recv_wait = 0;
  int      cycle_count = 0;
  bit      calm = 1'b0;
  logic [63:0] next_stamp;

  tx_block_sequence_assembler u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Work out the result of one item and advance the fill state
  function automatic result_t place_item(item_t it);
    result_t            r;
    logic [BYTES_W-1:0] size;
    logic [BYTES_W-1:0] off;
    logic [BYTES_W-1:0] room;
    logic [BYTES_W-1:0] take;
    logic               first;
    logic               stamp_now;
    r = '0;
    size = (reg_size > SIZE_LIMIT) ? SIZE_LIMIT : reg_size;
    if (it.func == FUNC_PUSH) begin
      if (fill_used >= size) begin
        fill_used = '0;
        run_stamp = run_stamp + {32'd0, reg_step};
        r.verdict = VERDICT_PUSHED;
      end else begin
        r.verdict = VERDICT_NOT_READY;
      end
    end else if (fill_used >= size) begin
      r.verdict = VERDICT_FULL;
    end else if (it.hdr_magic != reg_magic) begin
      r.verdict = VERDICT_BAD_MAGIC;
    end else begin
      first = (fill_used == '0);
      stamp_now = first && reg_stamp_en;
      off = fill_used;
      room = size - fill_used;
      if (stamp_now) begin
        room = (room >= STAMP_BYTES) ? room - STAMP_BYTES : '0;
        off = off + STAMP_BYTES;
      end
      take = (BYTES_W'(it.payload_bytes) < room) ? BYTES_W'(it.payload_bytes) : room;
      if (take == '0) begin
        r.verdict = VERDICT_EMPTY;
      end else if (first) begin
        if (it.hdr_block_index != 16'd0) begin
          r.verdict = VERDICT_AWAIT;
        end else begin
          // Flag a start stamp that lags or leads the expected one
          r.time_wrap = (it.hdr_seqno < run_stamp);
          r.time_gap = (it.hdr_seqno > run_stamp);
          last_blk = 16'd0;
          blk_total = it.hdr_block_count;
          run_stamp = it.hdr_seqno;
          r.verdict = VERDICT_ACCEPT;
        end
      end else if ((17'(last_blk) + 17'd1) != 17'(it.hdr_block_index) ||
                   blk_total != it.hdr_block_count || run_stamp != it.hdr_seqno) begin
        // Drop the fill on any broken continuation
        fill_used = '0;
        r.verdict = VERDICT_ORDER;
      end else begin
        last_blk = it.hdr_block_index;
        r.verdict = VERDICT_ACCEPT;
      end
      if (r.verdict == VERDICT_ACCEPT) begin
        r.write_offset = off;
        r.accepted_bytes = take[15:0];
        fill_used = fill_used + take;
        if (stamp_now) begin
          fill_used = fill_used + STAMP_BYTES;
          r.stamp_write = 1'b1;
          r.stamp_value = it.hdr_seqno;
        end
      end
    end
    r.buffer_ready = (fill_used >= size);
    r.fill_level = fill_used;
    return r;
  endfunction

  // Source side: hold each item until taken, then wait a drawn gap
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (in_tvalid) begin
        expected_results.push_back(place_item(item_on_bus));
        items_taken++;
      end
      if (send_wait > 0) begin
        send_wait--;
        in_tvalid <= 1'b0;
      end else if (pending_items.size() > 0) begin
        item_on_bus = pending_items.pop_front();
        in_tdata <= {item_on_bus.payload_bytes, item_on_bus.hdr_block_count,
                     item_on_bus.hdr_block_index, item_on_bus.hdr_seqno,
                     item_on_bus.hdr_magic};
        in_tuser <= item_on_bus.func;
        in_tvalid <= 1'b1;
        send_wait = calm ? 0 : $urandom_range(0, 7);
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] exp_val);
    if (mismatches < PRINT_CAP)
      $display("[%0t] result %0d: %s got 0x%0h, expected 0x%0h",
               $time, results_seen, what, got, exp_val);
    mismatches++;
  endtask

  task automatic check_field(string what, logic [63:0] got, logic [63:0] exp_val);
    if (got !== exp_val) report_mismatch(what, got, exp_val);
  endtask

  // Sink side: compare each taken result with the oldest prediction
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result, verdict", 64'(out_tuser), 64'd0);
        end else begin
          want = expected_results.pop_front();
          verdict_count[want.verdict]++;
          check_field("verdict", 64'(out_tuser), 64'(want.verdict));
          check_field("write_offset", 64'(out_tdata[20:0]), 64'(want.write_offset));
          check_field("accepted_bytes", 64'(out_tdata[36:21]), 64'(want.accepted_bytes));
          check_field("stamp_write", 64'(out_tdata[37]), 64'(want.stamp_write));
          check_field("stamp_value", out_tdata[101:38], want.stamp_value);
          check_field("buffer_ready", 64'(out_tdata[102]), 64'(want.buffer_ready));
          check_field("time_wrap", 64'(out_tdata[103]), 64'(want.time_wrap));
          check_field("time_gap", 64'(out_tdata[104]), 64'(want.time_gap));
          check_field("fill_level", 64'(out_tdata[125:105]), 64'(want.fill_level));
          check_field("tdata pad", 64'(out_tdata[127:126]), 64'd0);
        end
        results_seen++;
        recv_wait = calm ? 0 : $urandom_range(0, 7);
      end
      if (recv_wait > 0) begin
        recv_wait--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Bound the run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d of %0d items taken",
               cycle_count, items_taken, items_queued);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic write_reg(cfg_index_t which, logic [31:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= which;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (which)
      CFG_MAGIC_WORD:  reg_magic = value;
      CFG_BUFFER_SIZE: reg_size = value[BYTES_W-1:0];
      CFG_STAMP_EN:    reg_stamp_en = value[0];
      CFG_STAMP_STEP:  reg_step = value;
      default: ;
    endcase
  endtask

  task automatic setup(logic [31:0] magic, logic [31:0] size, bit stamp_en,
                       logic [31:0] step);
    write_reg(CFG_MAGIC_WORD, magic);
    write_reg(CFG_BUFFER_SIZE, size);
    write_reg(CFG_STAMP_EN, 32'(stamp_en));
    write_reg(CFG_STAMP_STEP, step);
    settings_used++;
  endtask

  task automatic add_header(logic [31:0] magic, logic [63:0] seq, logic [15:0] idx,
                            logic [15:0] cnt, logic [15:0] pay);
    item_t it;
    it.func = FUNC_HEADER;
    it.hdr_magic = magic;
    it.hdr_seqno = seq;
    it.hdr_block_index = idx;
    it.hdr_block_count = cnt;
    it.payload_bytes = pay;
    pending_items.push_back(it);
    items_queued++;
  endtask

  // Push items carry random header fields, which the block ignores
  task automatic add_push();
    item_t it;
    it = {FUNC_PUSH, $urandom(), $urandom(), $urandom(), 16'($urandom()),
          16'($urandom()), 16'($urandom())};
    pending_items.push_back(it);
    items_queued++;
  endtask

  // Wait until every item is taken and every result checked, then settle
  task automatic drain();
    do @(posedge clk);
    while (items_taken != items_queued || expected_results.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  // Mostly well-formed fills with random content, plus noise and broken fills
  task automatic queue_traffic(int count);
    int unsigned  size;
    int unsigned  pay_cap;
    int unsigned  blocks;
    int unsigned  roll;
    int           start;
    logic [63:0]  seq;
    logic [63:0]  s;
    logic [31:0]  magic;
    logic [15:0]  idx;
    logic [15:0]  cnt;
    logic [15:0]  pay;
    size = 32'((reg_size > SIZE_LIMIT) ? SIZE_LIMIT : reg_size);
    pay_cap = size / 3;
    if (pay_cap < 1) pay_cap = 1;
    if (pay_cap > 65535) pay_cap = 65535;
    start = items_queued;
    while (items_queued - start < count) begin
      roll = $urandom_range(0, 99);
      if (roll < 10) begin
        add_header($urandom(), {$urandom(), $urandom()}, 16'($urandom()),
                   16'($urandom()), 16'($urandom()));
      end else if (roll < 18) begin
        add_push();
      end else begin
        blocks = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 65535)
                                             : $urandom_range(1, 6);
        case ($urandom_range(0, 3))
          0, 1:    seq = next_stamp;
          2:       seq = next_stamp + 64'($urandom_range(1, 1000));
          default: seq = next_stamp - 64'($urandom_range(1, 1000));
        endcase
        for (int b = 0; b < ((blocks == 0) ? 1 : (blocks > 8 ? 8 : blocks)); b++) begin
          idx = 16'(b);
          cnt = 16'(blocks);
          s = seq;
          magic = reg_magic;
          roll = $urandom_range(0, 99);
          if (roll < 4) idx = 16'($urandom());
          else if (roll < 8) cnt = 16'($urandom());
          else if (roll < 12) s = s ^ (64'd1 << $urandom_range(0, 63));
          else if (roll < 15) magic = magic ^ (32'd1 << $urandom_range(0, 31));
          roll = $urandom_range(0, 99);
          if (roll < 5) pay = 16'd0;
          else if (roll < 10) pay = 16'hFFFF;
          else pay = 16'($urandom_range(1, pay_cap));
          add_header(magic, s, idx, cnt, pay);
        end
        roll = $urandom_range(0, 2);
        if (roll > 0) next_stamp = seq + {32'd0, reg_step};
        repeat (roll) add_push();
      end
    end
  endtask

  initial begin
    logic [31:0] m;
    reg_magic = 32'd0;
    reg_size = BYTES_W'(65536);
    reg_stamp_en = 1'b0;
    reg_step = 32'd0;
    fill_used = '0;
    last_blk = '0;
    blk_total = '0;
    run_stamp = '0;
    foreach (verdict_count[i]) verdict_count[i] = 0;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Small stamped buffer: each verdict, clipping, wrap and gap, stamp rollover
    m = 32'hA5A5_5A5A;
    setup(m, 64, 1'b1, 32'd100);
    add_push();
    add_header(32'h5A5A_A5A5, 64'd0, 16'd0, 16'd4, 16'd20);
    add_header(m, 64'd0, 16'd3, 16'd4, 16'd10);
    add_header(m, 64'd0, 16'd0, 16'd4, 16'd0);
    add_header(m, 64'd0, 16'd0, 16'd4, 16'd20);
    add_header(m, 64'd0, 16'd1, 16'd4, 16'd10);
    add_header(m, 64'd0, 16'd3, 16'd4, 16'd10);
    add_header(m, 64'd5, 16'd0, 16'd2, 16'hFFFF);
    add_header(m, 64'd5, 16'd1, 16'd2, 16'd1);
    add_push();
    add_header(m, 64'd50, 16'd0, 16'd3, 16'd8);
    add_header(m, 64'd50, 16'd1, 16'd7, 16'd8);
    add_header(m, '1, 16'd0, 16'hFFFF, 16'd40);
    add_header(m, '1, 16'd1, 16'hFFFF, 16'd4);
    add_header(m, 64'hFFFF_FFFF_FFFF_FFFE, 16'd2, 16'hFFFF, 16'd4);
    add_header(m, '1, 16'd0, 16'hFFFF, 16'hFFFF);
    add_push();
    add_header(m, 64'd99, 16'hFFFF, 16'd1, 16'd1);
    drain();

    // Buffer smaller than the stamp slot
    setup(32'd0, 4, 1'b1, 32'hFFFF_FFFF);
    add_header(32'd0, 64'd0, 16'd0, 16'd1, 16'd5);
    add_push();
    drain();

    // Unstamped fill, then shrink the buffer under it
    setup(32'd0, 1000, 1'b0, 32'd0);
    add_header(32'd0, 64'd99, 16'd0, 16'd2, 16'd100);
    drain();
    write_reg(CFG_BUFFER_SIZE, 32'd50);
    add_header(32'd0, 64'd99, 16'd1, 16'd2, 16'd10);
    add_push();
    drain();

    // Zero-size buffer, then the largest size word
    setup(32'd0, 0, 1'b0, 32'd0);
    add_header(32'd0, 64'd0, 16'd0, 16'd1, 16'd1);
    add_push();
    drain();
    setup(32'hFFFF_FFFF, 32'h001F_FFFF, 1'b1, 32'd1);
    add_header(32'hFFFF_FFFF, 64'd0, 16'd0, 16'd1, 16'hFFFF);
    drain();

    // Random traffic over a range of settings
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: setup($urandom(), 64, 1'b1, $urandom());
        1: setup(32'd0, 16, 1'b0, 32'd0);
        2: setup(32'hFFFF_FFFF, 300, 1'b1, 32'hFFFF_FFFF);
        3: setup($urandom(), MAX_BUFFER_BYTES, 1'b0, $urandom());
        4: setup($urandom(), 32'h001F_FFFF, 1'b1, 32'd1);
        default: setup($urandom(), $urandom_range(16, 512), 1'($urandom_range(0, 1)),
                       $urandom());
      endcase
      calm = (phase == 1 || phase == 4);
      next_stamp = run_stamp;
      queue_traffic(100);
      drain();
    end

    repeat (10) @(posedge clk);
    $display("Checked %0d results from %0d items over %0d register settings",
             results_seen, items_taken, settings_used);
    $display("accepted %0d, pushed %0d, out of order %0d, full %0d, mismatches %0d",
             verdict_count[VERDICT_ACCEPT], verdict_count[VERDICT_PUSHED],
             verdict_count[VERDICT_ORDER], verdict_count[VERDICT_FULL], mismatches);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+sv
sv/tbsa_pkg.sv
sv/tbsa_cfg_regs.sv
sv/tbsa_eval.sv
sv/tx_block_sequence_assembler.sv
tb/tb_top.sv
